// ===== rtl/spa_pkg.sv =====
// Package for the sparse polynomial arithmetic block: sizes, codes, word types.
// Used by spa_store, spa_alu and sparse_polynomial_arith; depends on nothing.
package spa_pkg;

    localparam int MAX_TERMS = 8;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    localparam int EXP_W     = 8;
    localparam int COEF_W    = 16;
    localparam int REXP_W    = 9;
    localparam int RCOEF_W   = 32;

    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [1:0]               kind;
        logic [EXP_W-1:0]         term_exponent;
        logic signed [COEF_W-1:0] term_coefficient;
    } t_in_word;

    typedef struct packed {
        logic [REXP_W-1:0]         result_exponent;
        logic signed [RCOEF_W-1:0] result_coefficient;
        logic                      last_term;
    } t_out_word;

    typedef struct packed {
        logic [EXP_W-1:0]         exponent;
        logic signed [COEF_W-1:0] coefficient;
    } t_term;

    // Operation select for the shared arithmetic unit.
    typedef struct packed {
        logic mul;
        logic take_a;
        logic take_b;
        logic negate_b;
    } t_alu_ctl;

endpackage

// ===== rtl/sparse_polynomial_arith.sv =====
// Sparse polynomial arithmetic: load, clear and run sequencer around two term stores.
// Loads and clears are taken while idle; a run emits one result word per cycle while the
// output is not stalled, through the output register (na+nb at most for add/subtract,
// na*nb for multiply), and the input is stalled until the last word is formed.
// Reset (synchronous, active low) empties both stores and sets the mode to add.
// Depends on spa_pkg, spa_store, spa_alu.
module sparse_polynomial_arith (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  spa_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output spa_pkg::t_out_word o_out_word,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_data
);

    localparam int CW = spa_pkg::CNT_W;

    spa_pkg::t_state    r_state, n_state;
    logic [1:0]         r_mode;
    logic [CW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    logic               r_out_valid;
    spa_pkg::t_out_word r_out;

    logic               w_in_acc;
    logic               w_emit;
    logic               w_start;
    logic               w_last;
    logic               w_run_req;
    logic [CW-1:0]      w_na, w_nb;
    spa_pkg::t_term     w_a_term, w_b_term, w_wr_term;
    spa_pkg::t_alu_ctl  w_ctl;
    logic [spa_pkg::REXP_W-1:0]         w_exp;
    logic signed [spa_pkg::RCOEF_W-1:0] w_coef;
    logic               w_a_has, w_b_has;
    logic [CW-1:0]      w_i_inc, w_j_inc;
    logic [CW-1:0]      w_rd_i, w_rd_j;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= spa_pkg::MODE_ADD;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_run_req = w_in_acc && (i_in_word.kind == spa_pkg::KIND_RUN);
    assign w_wr_term = '{exponent: i_in_word.term_exponent,
                         coefficient: i_in_word.term_coefficient};

    // Address the stores with the index the next cycle works on.
    assign w_rd_i = w_start ? '0 : (w_emit ? n_i : r_i);
    assign w_rd_j = w_start ? '0 : (w_emit ? n_j : r_j);

    spa_store u_store_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_in_acc && (i_in_word.kind == spa_pkg::KIND_LOAD_A)),
        .i_clear   (w_in_acc && (i_in_word.kind == spa_pkg::KIND_CLEAR)),
        .i_wr_term (w_wr_term),
        .i_rd_idx  (w_rd_i[spa_pkg::IDX_W-1:0]),
        .o_rd_term (w_a_term),
        .o_count   (w_na)
    );

    spa_store u_store_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_in_acc && (i_in_word.kind == spa_pkg::KIND_LOAD_B)),
        .i_clear   (w_in_acc && (i_in_word.kind == spa_pkg::KIND_CLEAR)),
        .i_wr_term (w_wr_term),
        .i_rd_idx  (w_rd_j[spa_pkg::IDX_W-1:0]),
        .o_rd_term (w_b_term),
        .o_count   (w_nb)
    );

    // Skip runs that produce nothing.
    always_comb begin
        unique case (r_mode)
            spa_pkg::MODE_ADD,
            spa_pkg::MODE_SUB: w_start = w_run_req && ((w_na != '0) || (w_nb != '0));
            spa_pkg::MODE_MUL: w_start = w_run_req && (w_na != '0) && (w_nb != '0);
            default:           w_start = 1'b0;
        endcase
    end

    // Pick the head term(s) for this step.
    assign w_a_has = r_i < w_na;
    assign w_b_has = r_j < w_nb;

    always_comb begin
        w_ctl.mul      = (r_mode == spa_pkg::MODE_MUL);
        w_ctl.negate_b = (r_mode == spa_pkg::MODE_SUB);
        if (w_a_has && w_b_has) begin
            w_ctl.take_a = (w_a_term.exponent >= w_b_term.exponent);
            w_ctl.take_b = (w_a_term.exponent <= w_b_term.exponent);
        end else begin
            w_ctl.take_a = w_a_has;
            w_ctl.take_b = !w_a_has;
        end
    end

    spa_alu u_alu (
        .i_ctl         (w_ctl),
        .i_a           (w_a_term),
        .i_b           (w_b_term),
        .o_exponent    (w_exp),
        .o_coefficient (w_coef)
    );

    assign w_i_inc = r_i + CW'(1);
    assign w_j_inc = r_j + CW'(1);

    always_comb begin
        if (w_ctl.mul) begin
            w_last = (w_i_inc == w_na) && (w_j_inc == w_nb);
            if (w_j_inc == w_nb) begin
                n_i = w_i_inc;
                n_j = '0;
            end else begin
                n_i = r_i;
                n_j = w_j_inc;
            end
        end else begin
            n_i    = w_ctl.take_a ? w_i_inc : r_i;
            n_j    = w_ctl.take_b ? w_j_inc : r_j;
            w_last = (n_i == w_na) && (n_j == w_nb);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spa_pkg::ST_IDLE: if (w_start) n_state = spa_pkg::ST_RUN;
            spa_pkg::ST_RUN:  if (w_emit && w_last) n_state = spa_pkg::ST_IDLE;
            default:          n_state = spa_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        unique case (r_state)
            spa_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                w_emit     = 1'b0;
            end
            spa_pkg::ST_RUN: begin
                o_in_stall = 1'b1;
                w_emit     = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
                w_emit     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spa_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Indexes restart at each run; advance on every emitted word.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_i <= '0;
            r_j <= '0;
        end else if (w_emit) begin
            r_i <= n_i;
            r_j <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.result_exponent    <= w_exp;
            r_out.result_coefficient <= w_coef;
            r_out.last_term          <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== rtl/spa_store.sv =====
// Term store: up to spa_pkg::MAX_TERMS terms with a fill count and one registered read port.
// Depends on spa_pkg.
module spa_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic                     i_clear,
    input  spa_pkg::t_term           i_wr_term,
    input  logic [spa_pkg::IDX_W-1:0] i_rd_idx,
    output spa_pkg::t_term           o_rd_term,
    output logic [spa_pkg::CNT_W-1:0] o_count
);

    spa_pkg::t_term                r_mem [spa_pkg::MAX_TERMS];
    spa_pkg::t_term                r_rd_term;
    logic [spa_pkg::CNT_W-1:0]     r_count;
    logic [spa_pkg::CNT_W-1:0]     n_count;
    logic                          w_has_room;

    assign w_has_room = r_count < spa_pkg::CNT_W'(spa_pkg::MAX_TERMS);

    always_comb begin
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (i_wr_en && w_has_room) begin
            n_count = r_count + spa_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Drop the term when the store is full; the read word is registered and shows up in the cycle after its index.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_has_room) begin
            r_mem[r_count[spa_pkg::IDX_W-1:0]] <= i_wr_term;
        end
        r_rd_term <= r_mem[i_rd_idx];
    end

    assign o_rd_term = r_rd_term;
    assign o_count   = r_count;

endmodule

// ===== rtl/spa_alu.sv =====
// Shared arithmetic unit: merge sum/difference or term product of one A and one B term.
// Depends on spa_pkg.
module spa_alu (
    input  spa_pkg::t_alu_ctl                i_ctl,
    input  spa_pkg::t_term                   i_a,
    input  spa_pkg::t_term                   i_b,
    output logic [spa_pkg::REXP_W-1:0]       o_exponent,
    output logic signed [spa_pkg::RCOEF_W-1:0] o_coefficient
);

    logic signed [spa_pkg::RCOEF_W-1:0] w_a_ext;
    logic signed [spa_pkg::RCOEF_W-1:0] w_b_ext;
    logic signed [spa_pkg::RCOEF_W-1:0] w_a_op;
    logic signed [spa_pkg::RCOEF_W-1:0] w_b_op;

    assign w_a_ext = spa_pkg::RCOEF_W'(i_a.coefficient);
    assign w_b_ext = spa_pkg::RCOEF_W'(i_b.coefficient);

    always_comb begin
        w_a_op = i_ctl.take_a ? w_a_ext : '0;
        w_b_op = '0;
        if (i_ctl.take_b) begin
            w_b_op = i_ctl.negate_b ? -w_b_ext : w_b_ext;
        end
    end

    always_comb begin
        if (i_ctl.mul) begin
            o_exponent    = spa_pkg::REXP_W'(i_a.exponent) + spa_pkg::REXP_W'(i_b.exponent);
            o_coefficient = w_a_ext * w_b_ext;
        end else begin
            o_exponent    = i_ctl.take_a ? spa_pkg::REXP_W'(i_a.exponent)
                                         : spa_pkg::REXP_W'(i_b.exponent);
            o_coefficient = w_a_op + w_b_op;
        end
    end

endmodule

// ===== bench/sparse_polynomial_arith_tb.sv =====
// Self-checking bench for sparse_polynomial_arith: directed and random term loads, runs and clears
// in all modes, with random idling on both channels and one long output hold.
// Depends on spa_pkg and the sparse_polynomial_arith RTL.
module sparse_polynomial_arith_tb;

    import spa_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int         ITEM_TARGET   = 350;
    localparam int         SETTLE_CYCLES = 80;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         CYCLE_LIMIT   = 800000;

    // Tracks both term stores and the mode, and queues the terms each run should emit.
    class poly_scoreboard;
        t_out_word   expected_terms[$];
        logic [7:0]  a_exp[8];
        int          a_coef[8];
        logic [7:0]  b_exp[8];
        int          b_coef[8];
        int          a_n;
        int          b_n;
        logic [1:0]  mode;
        int          errors;
        int          checked;
        int          runs;

        function new();
            a_n = 0;
            b_n = 0;
            mode = MODE_ADD;
            errors = 0;
            checked = 0;
            runs = 0;
        endfunction

        function void set_mode(logic [1:0] m);
            mode = m;
        endfunction

        function void push_term(logic [8:0] e, int c);
            t_out_word t;
            t.result_exponent = e;
            t.result_coefficient = c;
            t.last_term = 1'b0;
            expected_terms.push_back(t);
        endfunction

        function void predict_merge(bit negate_b);
            int i;
            int j;
            int bc;
            i = 0;
            j = 0;
            while (i < a_n && j < b_n) begin
                bc = negate_b ? -b_coef[j] : b_coef[j];
                if (a_exp[i] == b_exp[j]) begin
                    push_term({1'b0, a_exp[i]}, a_coef[i] + bc);
                    i++;
                    j++;
                end else if (a_exp[i] > b_exp[j]) begin
                    push_term({1'b0, a_exp[i]}, a_coef[i]);
                    i++;
                end else begin
                    push_term({1'b0, b_exp[j]}, bc);
                    j++;
                end
            end
            for (; i < a_n; i++) push_term({1'b0, a_exp[i]}, a_coef[i]);
            for (; j < b_n; j++) push_term({1'b0, b_exp[j]}, negate_b ? -b_coef[j] : b_coef[j]);
        endfunction

        function void predict_product();
            for (int i = 0; i < a_n; i++) begin
                for (int j = 0; j < b_n; j++) begin
                    push_term({1'b0, a_exp[i]} + {1'b0, b_exp[j]}, a_coef[i] * b_coef[j]);
                end
            end
        endfunction

        function void note_input(t_in_word w);
            int before_n;
            before_n = expected_terms.size();
            case (w.kind)
                KIND_LOAD_A: begin
                    // drop the term once the store is full
                    if (a_n < MAX_TERMS) begin
                        a_exp[a_n] = w.term_exponent;
                        a_coef[a_n] = $signed(w.term_coefficient);
                        a_n++;
                    end
                end
                KIND_LOAD_B: begin
                    if (b_n < MAX_TERMS) begin
                        b_exp[b_n] = w.term_exponent;
                        b_coef[b_n] = $signed(w.term_coefficient);
                        b_n++;
                    end
                end
                KIND_RUN: begin
                    runs++;
                    case (mode)
                        MODE_ADD: predict_merge(1'b0);
                        MODE_SUB: predict_merge(1'b1);
                        MODE_MUL: predict_product();
                        default: ;
                    endcase
                    if (expected_terms.size() > before_n)
                        expected_terms[expected_terms.size() - 1].last_term = 1'b1;
                end
                default: begin
                    a_n = 0;
                    b_n = 0;
                end
            endcase
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (expected_terms.size() == 0) begin
                $error("unexpected result word: exponent %0d coefficient %0d last %0d",
                       got.result_exponent, $signed(got.result_coefficient), got.last_term);
                errors++;
                return;
            end
            want = expected_terms.pop_front();
            checked++;
            if (got.result_exponent !== want.result_exponent) begin
                $error("result_exponent: expected %0d, got %0d",
                       want.result_exponent, got.result_exponent);
                errors++;
            end
            if (got.result_coefficient !== want.result_coefficient) begin
                $error("result_coefficient: expected %0d, got %0d",
                       $signed(want.result_coefficient), $signed(got.result_coefficient));
                errors++;
            end
            if (got.last_term !== want.last_term) begin
                $error("last_term: expected %0d, got %0d", want.last_term, got.last_term);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_word  o_out_word;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data;

    poly_scoreboard sb = new();

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_pending = 1'b0;
    int items_sent   = 0;
    int mode_writes  = 0;

    sparse_polynomial_arith dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // Observe all three channels at the edge, before the block's outputs move.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_word);
            if (i_in_valid && !o_in_stall) sb.note_input(i_in_word);
            if (i_cfg_valid && o_cfg_ready) sb.set_mode(i_cfg_data);
        end
    end

    // Result side: random stall before each word, one long hold on request.
    initial begin : result_side
        int wait_len;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                wait_len = HOLD_CYCLES;
            end else begin
                wait_len = rx_idle_on ? $urandom_range(0, 6) : 0;
            end
            if (wait_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_len) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_word(input logic [1:0] kind, input logic [7:0] e, input logic [15:0] c);
        t_in_word w;
        int gap;
        w.kind = kind;
        w.term_exponent = e;
        w.term_coefficient = c;
        gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Run and clear ignore the term fields, so fill them with noise.
    task automatic send_cmd(input logic [1:0] kind);
        send_word(kind, 8'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        repeat (2) @(posedge i_clk);
        while (sb.expected_terms.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode_writes++;
    endtask

    task automatic run_sequence();
        logic [7:0]        a_e[$];
        logic [7:0]        b_e[$];
        logic signed [15:0] a_c[$];
        logic signed [15:0] b_c[$];
        int na;
        int nb;
        int ia;
        int ib;
        na = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 8);
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 8);
        for (int k = 0; k < na; k++) a_e.push_back(8'($urandom));
        for (int k = 0; k < nb; k++) begin
            if (a_e.size() > 0 && $urandom_range(0, 2) == 0)
                b_e.push_back(a_e[$urandom_range(0, a_e.size() - 1)]);
            else
                b_e.push_back(8'($urandom));
        end
        // mostly descending lists; leave some as drawn
        if ($urandom_range(0, 5) != 0) begin
            a_e.rsort();
            b_e.rsort();
        end
        for (int k = 0; k < na; k++) begin
            case ($urandom_range(0, 5))
                0: a_c.push_back(16'sh7fff);
                1: a_c.push_back(16'sh8000);
                default: a_c.push_back(16'($urandom));
            endcase
        end
        for (int k = 0; k < nb; k++) b_c.push_back(16'($urandom));
        // match some coefficients on shared exponents to hit zero sums
        for (int j = 0; j < nb; j++) begin
            for (int i = 0; i < na; i++) begin
                if (a_e[i] == b_e[j] && $urandom_range(0, 1) == 1) begin
                    b_c[j] = $urandom_range(0, 1) ? a_c[i] : -a_c[i];
                    break;
                end
            end
        end
        send_cmd(KIND_CLEAR);
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb) begin
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
                send_word(KIND_LOAD_A, a_e[ia], a_c[ia]);
                ia++;
            end else begin
                send_word(KIND_LOAD_B, b_e[ib], b_c[ib]);
                ib++;
            end
        end
        send_cmd(KIND_RUN);
        if ($urandom_range(0, 3) == 0) send_cmd(KIND_RUN);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6)) send_word(2'($urandom), 8'($urandom), 16'($urandom));
    endtask

    initial begin : stimulus
        logic [1:0] m;
        int phase;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= MODE_ADD;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty run, extreme terms, zero sum, leftover A term.
        send_cmd(KIND_RUN);
        send_word(KIND_LOAD_A, 8'd255, 16'sh7fff);
        send_word(KIND_LOAD_A, 8'd7, 16'd100);
        send_word(KIND_LOAD_A, 8'd0, 16'sh8000);
        send_word(KIND_LOAD_B, 8'd255, 16'sh8000);
        send_word(KIND_LOAD_B, 8'd7, -16'sd100);
        send_cmd(KIND_RUN);
        write_mode(MODE_SUB);
        send_cmd(KIND_RUN);
        write_mode(MODE_MUL);
        send_cmd(KIND_RUN);
        // Fill both stores out of order, then one dropped term each.
        send_word(KIND_LOAD_A, 8'd3, 16'($urandom));
        send_word(KIND_LOAD_A, 8'd200, 16'($urandom));
        send_word(KIND_LOAD_A, 8'd1, 16'($urandom));
        send_word(KIND_LOAD_A, 8'd200, 16'($urandom));
        send_word(KIND_LOAD_A, 8'd9, 16'($urandom));
        send_word(KIND_LOAD_A, 8'd77, 16'($urandom));
        send_word(KIND_LOAD_B, 8'd255, 16'sh7fff);
        send_word(KIND_LOAD_B, 8'd0, 16'($urandom));
        send_word(KIND_LOAD_B, 8'd128, 16'($urandom));
        send_word(KIND_LOAD_B, 8'd2, 16'($urandom));
        send_word(KIND_LOAD_B, 8'd64, 16'($urandom));
        send_word(KIND_LOAD_B, 8'd0, 16'sh8000);
        send_word(KIND_LOAD_B, 8'd33, 16'($urandom));
        send_cmd(KIND_RUN);
        write_mode(MODE_ADD);
        send_cmd(KIND_RUN);
        write_mode(MODE_RESERVED);
        send_cmd(KIND_RUN);
        // Only B loaded: merges pass B through (negated for subtract), multiply yields nothing.
        send_cmd(KIND_CLEAR);
        send_word(KIND_LOAD_B, 8'd9, -16'sd7);
        write_mode(MODE_ADD);
        send_cmd(KIND_RUN);
        write_mode(MODE_MUL);
        send_cmd(KIND_RUN);
        write_mode(MODE_SUB);
        send_cmd(KIND_RUN);

        phase = 0;
        items_sent = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase == 2)
                m = MODE_MUL;
            else
                m = ($urandom_range(0, 9) == 0) ? MODE_RESERVED : 2'($urandom_range(0, 2));
            write_mode(m);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            // hold the result side while loads and runs keep coming
            if (phase == 2) hold_pending = 1'b1;
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    run_sequence();
            end
            phase++;
        end
        i_in_valid <= 1'b0;
        wait_drained();

        $display("Covered %0d runs and %0d random input words over %0d mode writes in %0d phases.",
                 sb.runs, items_sent, mode_writes, phase);
        $display("Compared %0d result words, with one %0d-cycle output hold.",
                 sb.checked, HOLD_CYCLES);
        if (sb.errors == 0 && sb.expected_terms.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
